// ===== hw/rtl/ppu_scroll_address_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ppu scroll address unit assertion macros
// concurrent checks, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef PPU_SCROLL_ADDRESS_UNIT_DEFINES_SVH
`define PPU_SCROLL_ADDRESS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// consequent holds in the same cycle as the antecedent
`define PSAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psau check failed in the same cycle");
// consequent holds in the cycle after the antecedent
`define PSAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psau check failed one cycle later");
`else
`define PSAU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PSAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/psau_pkg.sv =====
// ----------------------------------------------------------------------------
// psau_pkg
// types and constants shared by the scroll address unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psau_pkg;

    localparam int unsigned ADDR_W = 15;

    typedef enum logic [2:0] {
        OP_REG_WRITE   = 3'd0,
        OP_STATUS_READ = 3'd1,
        OP_DATA_READ   = 3'd2,
        OP_INC_X       = 3'd3,
        OP_INC_Y       = 3'd4,
        OP_COPY_HORIZ  = 3'd5,
        OP_COPY_VERT   = 3'd6
    } t_op;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [ADDR_W-1:0] FINE_Y_BITS   = 15'h7000;
    localparam logic [ADDR_W-1:0] COARSE_Y_BITS = 15'h03E0;
    localparam logic [ADDR_W-1:0] VERT_NT_BIT   = 15'h0800;
    localparam logic [ADDR_W-1:0] HORIZ_BITS    = 15'h041F;
    localparam logic [ADDR_W-1:0] VERT_BITS     = 15'h7BE0;
    localparam logic [ADDR_W-1:0] PALETTE_BASE  = 15'h3F00;
    localparam logic [ADDR_W-1:0] SCROLL_KEEP   = 15'h0C1F;
    localparam logic [4:0]        ROW_LAST      = 5'd29;
    localparam logic [4:0]        ROW_MAX       = 5'd31;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] reg_index;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] cur_addr;
        logic [ADDR_W-1:0] temp_addr;
        logic [2:0]        fine_x;
        logic              write_toggle;
        logic              step_by_row;
        logic              render_enable;
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] access_addr;
        logic [ADDR_W-1:0] vram_addr;
        logic [2:0]        fine_x_out;
        logic              toggle_out;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/psau_item_if.sv =====
// ----------------------------------------------------------------------------
// psau_item_if
// input operation channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psau_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [2:0] reg_index;
    logic [7:0] data;

    modport source (output valid, output op, output reg_index, output data, input ready);
    modport sink   (input valid, input op, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/psau_result_if.sv =====
// ----------------------------------------------------------------------------
// psau_result_if
// result channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psau_result_if;
    logic        valid;
    logic        ready;
    logic [14:0] access_addr;
    logic [14:0] vram_addr;
    logic [2:0]  fine_x_out;
    logic        toggle_out;

    modport source (output valid, output access_addr, output vram_addr,
                    output fine_x_out, output toggle_out, input ready);
    modport sink   (input valid, input access_addr, input vram_addr,
                    input fine_x_out, input toggle_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/psau_update.sv =====
// ----------------------------------------------------------------------------
// psau_update
// next-state and result logic for one operation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psau_update (
    input  psau_pkg::t_state  i_state,
    input  psau_pkg::t_item   i_item,
    output psau_pkg::t_state  o_state,
    output psau_pkg::t_result o_result
);

    logic [14:0] w_cur;
    logic [14:0] w_port_next;
    logic [14:0] w_inc_x;
    logic [14:0] w_inc_y;
    logic [14:0] w_copy_h;
    logic [14:0] w_copy_v;
    logic [14:0] w_addr_lo;
    logic [4:0]  w_row;
    logic [4:0]  w_row_next;
    logic [14:0] w_row_wrap;

    assign w_cur       = i_state.cur_addr;
    assign w_port_next = w_cur + (i_state.step_by_row ? 15'd32 : 15'd1);

    // coarse x wraps into the other horizontal nametable
    assign w_inc_x = (w_cur[4:0] == 5'h1F)
                   ? ({w_cur[14:5], 5'd0} ^ 15'h0400)
                   : (w_cur + 15'd1);

    assign w_row      = w_cur[9:5];
    assign w_row_next = ((w_row == psau_pkg::ROW_LAST) || (w_row == psau_pkg::ROW_MAX))
                      ? 5'd0 : (w_row + 5'd1);
    // last visible row flips the vertical nametable, row 31 does not
    assign w_row_wrap = ((w_cur & ~(psau_pkg::FINE_Y_BITS | psau_pkg::COARSE_Y_BITS))
                         ^ ((w_row == psau_pkg::ROW_LAST) ? psau_pkg::VERT_NT_BIT : 15'd0))
                      | {5'd0, w_row_next, 5'd0};
    assign w_inc_y = ((w_cur & psau_pkg::FINE_Y_BITS) == psau_pkg::FINE_Y_BITS)
                   ? w_row_wrap : (w_cur + 15'h1000);

    assign w_copy_h = (w_cur & ~psau_pkg::HORIZ_BITS)
                    | (i_state.temp_addr & psau_pkg::HORIZ_BITS);
    assign w_copy_v = (w_cur & ~psau_pkg::VERT_BITS)
                    | (i_state.temp_addr & psau_pkg::VERT_BITS);

    assign w_addr_lo = {i_state.temp_addr[14:8], i_item.data};

    always_comb begin
        o_state = i_state;
        unique case (psau_pkg::t_op'(i_item.op))
            psau_pkg::OP_REG_WRITE: begin
                unique case (i_item.reg_index)
                    psau_pkg::REG_CTRL: begin
                        o_state.temp_addr[11:10] = i_item.data[1:0];
                        o_state.step_by_row      = i_item.data[2];
                    end
                    psau_pkg::REG_MASK: begin
                        o_state.render_enable = i_item.data[3] | i_item.data[4];
                    end
                    psau_pkg::REG_SCROLL: begin
                        if (!i_state.write_toggle) begin
                            o_state.temp_addr[4:0] = i_item.data[7:3];
                            o_state.fine_x         = i_item.data[2:0];
                        end else begin
                            o_state.temp_addr = (i_state.temp_addr & psau_pkg::SCROLL_KEEP)
                                              | {i_item.data[2:0], 2'b00,
                                                 i_item.data[7:3], 5'd0};
                        end
                        o_state.write_toggle = ~i_state.write_toggle;
                    end
                    psau_pkg::REG_ADDR: begin
                        if (!i_state.write_toggle) begin
                            o_state.temp_addr = {1'b0, i_item.data[5:0],
                                                 i_state.temp_addr[7:0]};
                        end else begin
                            o_state.temp_addr = w_addr_lo;
                            o_state.cur_addr  = w_addr_lo;
                        end
                        o_state.write_toggle = ~i_state.write_toggle;
                    end
                    psau_pkg::REG_DATA: begin
                        o_state.cur_addr = w_port_next;
                    end
                    default: begin
                        o_state = i_state;
                    end
                endcase
            end
            psau_pkg::OP_STATUS_READ: begin
                o_state.write_toggle = 1'b0;
            end
            psau_pkg::OP_DATA_READ: begin
                if (w_cur < psau_pkg::PALETTE_BASE) begin
                    o_state.cur_addr = w_port_next;
                end
            end
            psau_pkg::OP_INC_X: begin
                if (i_state.render_enable) o_state.cur_addr = w_inc_x;
            end
            psau_pkg::OP_INC_Y: begin
                if (i_state.render_enable) o_state.cur_addr = w_inc_y;
            end
            psau_pkg::OP_COPY_HORIZ: begin
                if (i_state.render_enable) o_state.cur_addr = w_copy_h;
            end
            psau_pkg::OP_COPY_VERT: begin
                if (i_state.render_enable) o_state.cur_addr = w_copy_v;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    always_comb begin
        o_result.access_addr = w_cur;
        o_result.vram_addr   = o_state.cur_addr;
        o_result.fine_x_out  = o_state.fine_x;
        o_result.toggle_out  = o_state.write_toggle;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ppu_scroll_address_unit.sv =====
// ----------------------------------------------------------------------------
// ppu_scroll_address_unit
// scroll and video address registers (v, t, fine x, write toggle)
// ----------------------------------------------------------------------------
// One operation is taken per clock while the result is not stalled, and each
// gives exactly one result. An accepted operation lands in the input register;
// when it advances, the update logic applies it to the address state and loads
// the result register, from which the result is offered. The state loop closes
// through that single update stage, which sets the rate of one operation per
// cycle; a stalled result holds the input register, and the input takes a new
// item whenever the input register is empty or drains in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "ppu_scroll_address_unit_defines.svh"

module ppu_scroll_address_unit (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    psau_item_if.sink     i_in,
    psau_result_if.source o_out
);

    logic               r_in_valid;
    psau_pkg::t_item    r_item;
    psau_pkg::t_state   r_state;
    psau_pkg::t_state   n_state;
    logic               r_out_valid;
    psau_pkg::t_result  r_res;
    psau_pkg::t_result  n_res;
    logic               w_adv;
    logic               w_state_match;
    logic               w_status_op;
    logic               w_render_idle;
    logic               w_res_unmoved;

    // input register moves on when the result slot is free or being taken
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    psau_update u_update (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.op        <= i_in.op;
            r_item.reg_index <= i_in.reg_index;
            r_item.data      <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.access_addr = r_res.access_addr;
    assign o_out.vram_addr   = r_res.vram_addr;
    assign o_out.fine_x_out  = r_res.fine_x_out;
    assign o_out.toggle_out  = r_res.toggle_out;

    assign w_state_match = (r_state.cur_addr == r_res.vram_addr)
                         && (r_state.fine_x == r_res.fine_x_out)
                         && (r_state.write_toggle == r_res.toggle_out);
    assign w_status_op   = (psau_pkg::t_op'(r_item.op) == psau_pkg::OP_STATUS_READ);
    assign w_render_idle = !r_state.render_enable
                         && ((psau_pkg::t_op'(r_item.op) == psau_pkg::OP_INC_X)
                          || (psau_pkg::t_op'(r_item.op) == psau_pkg::OP_INC_Y)
                          || (psau_pkg::t_op'(r_item.op) == psau_pkg::OP_COPY_HORIZ)
                          || (psau_pkg::t_op'(r_item.op) == psau_pkg::OP_COPY_VERT));
    assign w_res_unmoved = (r_res.vram_addr == r_res.access_addr);

    // the held state always matches the most recent result
    `PSAU_ASSERT_NEXT(a_state_tracks_result, i_clk, i_rst_n, w_adv, w_state_match)

    // status read always leaves the toggle clear
    `PSAU_ASSERT_NEXT(a_status_clears_toggle, i_clk, i_rst_n, w_adv && w_status_op, !r_res.toggle_out)

    // rendering operations are inert with rendering off
    `PSAU_ASSERT_NEXT(a_render_off_inert, i_clk, i_rst_n, w_adv && w_render_idle, w_res_unmoved)

    // a result is never overwritten while it waits
    `PSAU_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_out.ready, !w_adv)

endmodule

`default_nettype wire
